/* sv/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants of the linear blend skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;
	localparam int NumBones     = 16;
	localparam int FracBits     = 16;
	localparam int WordsPerBone = 12;
	localparam int WeightBits   = 16;
	localparam int BoneW        = 4;
	localparam int TabDepth     = NumBones * WordsPerBone;
	localparam int TabAw        = $clog2(TabDepth);
	localparam int AccW         = 48;
	localparam int SumW         = 68;
	localparam int QDepth       = 2;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_TERM = 1'b1
	} cmd_t;

	// One queued term, ready for the back end
	typedef struct packed {
		logic               in_range;
		logic [TabAw-1:0]   base;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic [16:0]        w;
		logic               last;
	} term_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_EMIT
	} bk_state_t;
endpackage

/* sv/lbs_front.sv */
// ----------------------------------------------------------------------------
// lbs_front
// Accepts items, classifies them and queues bone terms for the back end.
// ----------------------------------------------------------------------------
module lbs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	output logic                    stall,
	input  logic                    cmd,
	input  logic [3:0]              bone,
	input  logic [3:0]              word_index,
	input  logic                    term_pop,
	input  logic                    busy,
	output logic                    term_avail,
	output lbs_pkg::term_t          term_head,
	output logic                    wr_en,
	output logic [lbs_pkg::TabAw-1:0] wr_addr,
	input  logic signed [31:0]      pos_x,
	input  logic signed [31:0]      pos_y,
	input  logic signed [31:0]      pos_z,
	input  logic [16:0]             weight,
	input  logic                    last_bone
);
	import lbs_pkg::*;

	term_t          q_q [QDepth];
	logic           rd_q, wr_q;
	logic [1:0]     cnt_q;
	logic           acc;
	logic           is_term;
	term_t          t;
	logic           in_rng;
	logic [TabAw:0] base_full;

	assign is_term = (cmd == CMD_TERM);
	// hold a load until every earlier term has read the table
	assign stall   = is_term ? (cnt_q == 2'(QDepth)) : (term_avail || busy);
	assign acc     = valid && !stall;
	assign in_rng  = 32'(bone) < NumBones;
	assign base_full = (TabAw+1)'(32'(bone) * WordsPerBone);

	assign wr_en   = acc && !is_term && in_rng && (32'(word_index) < WordsPerBone);
	assign wr_addr = TabAw'(base_full + (TabAw+1)'(word_index));

	always_comb begin
		t          = '0;
		t.in_range = in_rng;
		t.base     = base_full[TabAw-1:0];
		t.px       = pos_x;
		t.py       = pos_y;
		t.pz       = pos_z;
		t.w        = (weight > 17'd65536) ? 17'd65536 : weight;
		t.last     = last_bone;
	end

	always_ff @(posedge clk) begin
		if (acc && is_term)
			q_q[wr_q] <= t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (acc && is_term)
				wr_q <= ~wr_q;
			if (term_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(acc && is_term) - 2'(term_pop);
		end
	end

	assign term_avail = (cnt_q != '0);
	assign term_head  = q_q[rd_q];
endmodule

/* sv/lbs_back.sv */
// ----------------------------------------------------------------------------
// lbs_back
// Holds the transform table and works one term at a time, its rotation products through a shared multiplier.
// ----------------------------------------------------------------------------
module lbs_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [lbs_pkg::TabAw-1:0] wr_addr,
	input  logic [31:0]               wr_data,
	input  logic                      term_avail,
	input  lbs_pkg::term_t            term_head,
	output logic                      term_pop,
	output logic                      busy,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [31:0]        out_x,
	output logic signed [31:0]        out_y,
	output logic signed [31:0]        out_z
);
	import lbs_pkg::*;

	localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
	localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
	localparam logic [3:0]             LastStep = 4'd15;

	logic [31:0]             mem [TabDepth];
	logic [31:0]             rdata_q;
	logic [TabAw-1:0]        rd_addr;
	bk_state_t               st_q, st_d;
	term_t                   cur_q;
	logic [3:0]              cnt_q;
	logic                    take, hold, fire, mul_en;
	logic signed [31:0]      mul_b;
	logic [1:0]              mrow;
	logic signed [63:0]      prod_q;
	logic [1:0]              prow_q;
	logic                    prod_vld_q;
	logic signed [SumW-1:0]  rs_q [3];
	logic signed [31:0]      tr_q [3];
	logic signed [AccW-1:0]  c_q [3];
	logic signed [AccW+17:0] wp_q [3];
	logic signed [AccW-1:0]  acc_q [3];
	logic signed [SumW-1:0]  cfull [3];
	logic signed [AccW-1:0]  csat [3];
	logic signed [AccW+1:0]  wsum [3];
	logic signed [AccW-1:0]  nacc [3];
	logic signed [31:0]      ox_q, oy_q, oz_q;
	logic                    ov_q;

	function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
		if (v > 48'sh0000_7FFF_FFFF)      return 32'sh7FFF_FFFF;
		else if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
		else                               return v[31:0];
	endfunction

	assign rd_addr = cur_q.base + TabAw'(cnt_q);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (st_q == BK_RUN && cnt_q < 4'(WordsPerBone))
			rdata_q <= mem[rd_addr];
	end

	assign take     = (st_q == BK_IDLE) && term_avail;
	assign term_pop = take;
	assign busy     = (st_q != BK_IDLE);
	// a last term waits while the previous result is still stalled
	assign hold     = cur_q.last && ov_q && out_stall;
	assign fire     = (st_q == BK_EMIT) && cur_q.last && !hold;
	assign mul_en   = (st_q == BK_RUN) && (cnt_q inside {[4'd1:4'd9]});

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (take) st_d = BK_RUN;
			BK_RUN:  if (cnt_q == LastStep) st_d = BK_EMIT;
			BK_EMIT: if (!hold) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	// word cnt-1 sits in rdata_q: pick its position lane and matrix row
	always_comb begin
		case (cnt_q)
			4'd1, 4'd4, 4'd7: mul_b = cur_q.px;
			4'd2, 4'd5, 4'd8: mul_b = cur_q.py;
			default:          mul_b = cur_q.pz;
		endcase
		case (cnt_q)
			4'd1, 4'd2, 4'd3: mrow = 2'd0;
			4'd4, 4'd5, 4'd6: mrow = 2'd1;
			default:          mrow = 2'd2;
		endcase
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			cfull[r] = (rs_q[r] >>> FracBits) + SumW'(tr_q[r]);
			if (cfull[r] > SumW'(AccMax))      csat[r] = AccMax;
			else if (cfull[r] < SumW'(AccMin)) csat[r] = AccMin;
			else                               csat[r] = cfull[r][AccW-1:0];
			wsum[r] = (AccW+2)'(acc_q[r]) + (AccW+2)'(wp_q[r] >>> WeightBits);
			if (wsum[r] > (AccW+2)'(AccMax))      nacc[r] = AccMax;
			else if (wsum[r] < (AccW+2)'(AccMin)) nacc[r] = AccMin;
			else                                  nacc[r] = wsum[r][AccW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			cur_q <= term_head;
		if (mul_en) begin
			prod_q <= $signed(rdata_q) * mul_b;
			prow_q <= mrow;
		end
		if (st_q == BK_RUN && cnt_q == 4'd0) begin
			for (int r = 0; r < 3; r++) rs_q[r] <= '0;
		end else if (prod_vld_q)
			rs_q[prow_q] <= rs_q[prow_q] + SumW'(prod_q);
		if (st_q == BK_RUN) begin
			case (cnt_q)
				4'd10:   tr_q[0] <= $signed(rdata_q);
				4'd11:   tr_q[1] <= $signed(rdata_q);
				4'd12:   tr_q[2] <= $signed(rdata_q);
				4'd13: begin
					for (int r = 0; r < 3; r++) c_q[r] <= csat[r];
				end
				4'd14: begin
					for (int r = 0; r < 3; r++)
						wp_q[r] <= c_q[r] * $signed({1'b0, cur_q.w});
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= BK_IDLE;
			cnt_q      <= '0;
			prod_vld_q <= 1'b0;
			ov_q       <= 1'b0;
			ox_q       <= '0;
			oy_q       <= '0;
			oz_q       <= '0;
			for (int i = 0; i < 3; i++) acc_q[i] <= '0;
		end else begin
			st_q       <= st_d;
			cnt_q      <= (st_q == BK_RUN) ? cnt_q + 4'd1 : '0;
			prod_vld_q <= mul_en;
			ov_q       <= fire || (ov_q && out_stall);
			if (st_q == BK_RUN && cnt_q == LastStep && cur_q.in_range) begin
				for (int i = 0; i < 3; i++) acc_q[i] <= nacc[i];
			end
			if (fire) begin
				ox_q <= sat32(acc_q[0]);
				oy_q <= sat32(acc_q[1]);
				oz_q <= sat32(acc_q[2]);
				for (int i = 0; i < 3; i++) acc_q[i] <= '0;
			end
		end
	end

	assign out_valid = ov_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign out_z     = oz_q;
endmodule

/* sv/linear_blend_skinning_core.sv */
// ----------------------------------------------------------------------------
// linear_blend_skinning_core
// Linear blend skinning of vertex positions, Q16.16, one shared multiplier for rotation.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  input   | valid / stall            | cmd bone word_index word_value pos_* weight last_bone
//  output  | out_valid / out_stall    | out_x out_y out_z
//
// In the back end a bone term is taken from the queue, then twelve table
// reads feed one 32x32 multiplier for the nine rotation products, then come
// translation, saturation and the three weight products, and a last term's
// result is emitted. A last term waits there while the previous result stalls.
// A two-deep term queue lets terms enter while it works; a load stalls until
// the queue is empty and the back end idle.
// Reset clears control, outputs and the blend accumulators; the table is undefined until loaded.
module linear_blend_skinning_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic               cmd,
	input  logic [3:0]         bone,
	input  logic [3:0]         word_index,
	input  logic signed [31:0] word_value,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [16:0]        weight,
	input  logic               last_bone,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	import lbs_pkg::*;

	logic             term_pop, term_avail, wr_en, busy;
	term_t            term_head;
	logic [TabAw-1:0] wr_addr;

	lbs_front u_front (
		.clk, .arst_n, .valid, .stall, .cmd, .bone, .word_index,
		.term_pop, .busy, .term_avail, .term_head, .wr_en, .wr_addr,
		.pos_x, .pos_y, .pos_z, .weight, .last_bone
	);

	lbs_back u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data(word_value),
		.term_avail, .term_head, .term_pop, .busy,
		.out_valid, .out_stall, .out_x, .out_y, .out_z
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x))
		else $error("result dropped under stall");
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		term_pop |-> term_avail)
		else $error("term popped from empty queue");
endmodule
